>>> hdl/srqp_pkg.sv
package srqp_pkg;

  // Field widths of the packed record
  localparam int unsigned W_PRESSURE = 12;
  localparam int unsigned W_TEMP     = 9;
  localparam int unsigned W_ANGLE    = 9;
  localparam int unsigned W_HEADING  = 9;
  localparam int unsigned W_BATTERY  = 9;
  localparam int unsigned W_BYTE     = 8;
  localparam int unsigned W_SPEED    = 10;
  localparam int unsigned W_DIR      = 7;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CODE_W   = 12;
  localparam int unsigned WIDTH_W  = 4;
  localparam int unsigned BITS_W   = 13;
  localparam int unsigned HELD_W   = 3;

  localparam logic [7:0] MAX_PAIRS = 8'd255;

  // Result queue between packer and byte emitter
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Reciprocal multipliers (value * K) >> 16 for the division steps
  localparam int unsigned RECIP_W    = 14;
  localparam int unsigned RECIP_SH   = 16;
  localparam logic [RECIP_W-1:0] RECIP_DIV5  = 14'd13108;
  localparam logic [RECIP_W-1:0] RECIP_DIV10 = 14'd6554;
  localparam logic [RECIP_W-1:0] RECIP_DIV50 = 14'd1311;

  // Record field sequence; unused codes act as pressure
  typedef enum logic [3:0] {
    STEP_PRESSURE = 4'd0,
    STEP_TEMP     = 4'd1,
    STEP_PITCH    = 4'd2,
    STEP_ROLL     = 4'd3,
    STEP_HEADING  = 4'd4,
    STEP_BATTERY  = 4'd5,
    STEP_BLANKING = 4'd6,
    STEP_CELLS    = 4'd7,
    STEP_PAIRS    = 4'd8
  } step_t;

  // One quantized code headed for the packer
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] width;
    logic               rec_end;
  } code_item_t;

  // Bytes caused by one input item
  typedef struct packed {
    logic [2:0][7:0]   data;
    logic [1:0]        count;
    logic              rec_end;
    logic [BITS_W-1:0] total;
  } byte_group_t;

endpackage

>>> hdl/sensor_record_quantize_pack.sv
// An accepted field passes the code stage register, result queue and output register.
// Throughput: s_tready accepts one field per cycle while the result queue has room;
// the byte emitter sends one byte per cycle while m_tready is high, and each field
// causes zero to three bytes.
// Reset: synchronous rst clears the field sequence, bit accumulator, queue and output valid.
module sensor_record_quantize_pack import srqp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] packed_byte, [20:8] record_bits, [23:21] zero
  output logic        m_tlast,   // run_last
  output logic        m_tuser    // record_end
);

  logic              item_valid, item_take;
  code_item_t        item;
  logic              grp_push, grp_full, head_valid, pop;
  byte_group_t       grp, head_grp;
  logic [7:0]        packed_byte;
  logic [BITS_W-1:0] record_bits;

  srqp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample_value (s_tdata),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  srqp_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .grp_full   (grp_full),
    .grp_push   (grp_push),
    .grp        (grp)
  );

  srqp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (grp_push),
    .push_grp   (grp),
    .full       (grp_full),
    .head_valid (head_valid),
    .head_grp   (head_grp),
    .pop        (pop)
  );

  srqp_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_grp    (head_grp),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .packed_byte (packed_byte),
    .run_last    (m_tlast),
    .record_end  (m_tuser),
    .record_bits (record_bits)
  );

  assign m_tdata = {3'b000, record_bits, packed_byte};

endmodule

>>> hdl/srqp_front.sv
module srqp_front import srqp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample_value,
  output logic                item_valid,
  output code_item_t          item,
  input  logic                item_take
);

  step_t      field_step, field_step_next;
  logic [7:0] pairs_left, pairs_left_next;
  logic       pair_phase, pair_phase_next;
  logic       accept;

  logic signed [16:0]       ts, lo, hi, off;
  logic [4:0]               half;
  logic [RECIP_W-1:0]       recip;
  logic                     use_mul;
  logic [WIDTH_W-1:0]       width;
  logic [12:0]              x;
  logic [12+RECIP_W:0]      prod;
  logic [CODE_W:0]          top;
  logic [CODE_W-1:0]        qcode, code;
  logic [7:0]               cnt;
  logic                     is_byte, rec_end;

  assign in_ready = !item_valid || item_take;
  assign accept   = in_valid && in_ready;

  // Pick range, rounding and width for the current field
  always_comb begin
    lo      = '0;
    hi      = 17'sd2500;
    half    = '0;
    recip   = RECIP_DIV10;
    use_mul = 1'b0;
    width   = WIDTH_W'(W_PRESSURE);
    is_byte = 1'b0;
    cnt     = (sample_value[7:0] > MAX_PAIRS) ? MAX_PAIRS : sample_value[7:0];
    case (field_step)
      STEP_TEMP, STEP_BATTERY: begin
        hi    = 17'sd250;
        width = WIDTH_W'(W_TEMP);
      end
      STEP_PITCH, STEP_ROLL: begin
        lo      = -17'sd1800;
        hi      = 17'sd1800;
        half    = 5'd5;
        use_mul = 1'b1;
        width   = WIDTH_W'(W_ANGLE);
      end
      STEP_HEADING: begin
        hi      = 17'sd3600;
        half    = 5'd5;
        use_mul = 1'b1;
        width   = WIDTH_W'(W_HEADING);
      end
      STEP_BLANKING, STEP_CELLS: begin
        is_byte = 1'b1;
        width   = WIDTH_W'(W_BYTE);
      end
      STEP_PAIRS: begin
        use_mul = 1'b1;
        if (!pair_phase) begin
          hi    = 17'sd5000;
          half  = 5'd2;
          recip = RECIP_DIV5;
          width = WIDTH_W'(W_SPEED);
        end else begin
          hi    = 17'sd3600;
          half  = 5'd25;
          recip = RECIP_DIV50;
          width = WIDTH_W'(W_DIR);
        end
      end
      default: begin
      end
    endcase
  end

  // Quantize: offset, round half up, divide by reciprocal multiply
  always_comb begin
    ts    = 17'(signed'(sample_value));
    off   = ts - lo;
    x     = off[12:0] + 13'(half);
    prod  = x * recip;
    top   = (CODE_W+1)'(1) << width;
    qcode = use_mul ? CODE_W'(prod[12+RECIP_W:RECIP_SH]) : x[CODE_W-1:0];
    if (is_byte) begin
      code = (field_step == STEP_CELLS) ? CODE_W'(cnt) : CODE_W'(sample_value[7:0]);
    end else if (ts < lo) begin
      code = CODE_W'(top - (CODE_W+1)'(2));
    end else if (ts > hi) begin
      code = CODE_W'(top - (CODE_W+1)'(1));
    end else begin
      code = qcode;
    end
  end

  // Advance the field sequence
  always_comb begin
    field_step_next = field_step;
    pairs_left_next = pairs_left;
    pair_phase_next = pair_phase;
    rec_end         = 1'b0;
    case (field_step)
      STEP_TEMP:     field_step_next = STEP_PITCH;
      STEP_PITCH:    field_step_next = STEP_ROLL;
      STEP_ROLL:     field_step_next = STEP_HEADING;
      STEP_HEADING:  field_step_next = STEP_BATTERY;
      STEP_BATTERY:  field_step_next = STEP_BLANKING;
      STEP_BLANKING: field_step_next = STEP_CELLS;
      STEP_CELLS: begin
        if (cnt == 8'd0) begin
          rec_end = 1'b1;
        end else begin
          pairs_left_next = cnt;
          pair_phase_next = 1'b0;
          field_step_next = STEP_PAIRS;
        end
      end
      STEP_PAIRS: begin
        pair_phase_next = !pair_phase;
        if (pair_phase) begin
          pairs_left_next = pairs_left - 8'd1;
          rec_end         = (pairs_left == 8'd1);
        end
      end
      default: field_step_next = STEP_TEMP;
    endcase
    if (rec_end) begin
      field_step_next = STEP_PRESSURE;
      pairs_left_next = '0;
      pair_phase_next = 1'b0;
    end
  end

  // Hold sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      field_step <= STEP_PRESSURE;
      pairs_left <= '0;
      pair_phase <= 1'b0;
    end else if (accept) begin
      field_step <= field_step_next;
      pairs_left <= pairs_left_next;
      pair_phase <= pair_phase_next;
    end
  end

  // Code stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.code    <= code;
      item.width   <= width;
      item.rec_end <= rec_end;
    end
  end

endmodule

>>> hdl/srqp_pack.sv
module srqp_pack import srqp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  code_item_t  item,
  output logic        item_take,
  input  logic        grp_full,
  output logic        grp_push,
  output byte_group_t grp
);

  logic [6:0]        acc, acc_next;
  logic [HELD_W-1:0] held, held_next;
  logic [BITS_W-1:0] total, total_next;

  logic [19:0]       wide;
  logic [4:0]        hsum, sh0, sh1;
  logic [1:0]        nfull;
  logic [HELD_W-1:0] rem;
  logic [6:0]        rem_bits;
  logic [14:0]       flush_wide;
  logic [7:0]        byte0, byte1, flush;
  logic              do_flush;

  assign item_take = item_valid && !grp_full;

  // Append the code and split off complete bytes
  always_comb begin
    wide       = (20'(acc) << item.width) | 20'(item.code);
    hsum       = 5'(held) + 5'(item.width);
    sh0        = hsum - 5'd8;
    sh1        = hsum - 5'd16;
    byte0      = 8'(wide >> sh0);
    byte1      = 8'(wide >> sh1);
    nfull      = (hsum >= 5'd16) ? 2'd2 : ((hsum >= 5'd8) ? 2'd1 : 2'd0);
    rem        = hsum[HELD_W-1:0];
    rem_bits   = wide[6:0] & ((7'd1 << rem) - 7'd1);
    flush_wide = 15'(rem_bits) << (4'd8 - 4'(rem));
    flush      = flush_wide[7:0];
    do_flush   = item.rec_end && (rem != '0);
    total_next = total + BITS_W'(item.width);
    acc_next   = item.rec_end ? '0 : rem_bits;
    held_next  = item.rec_end ? '0 : rem;
  end

  // Build the byte group for the queue
  always_comb begin
    grp.data    = {flush, byte1, byte0};
    if (nfull == 2'd1) begin
      grp.data[1] = flush;
    end else if (nfull == 2'd0) begin
      grp.data[0] = flush;
    end
    grp.count   = nfull + 2'(do_flush);
    grp.rec_end = item.rec_end;
    grp.total   = total_next;
    grp_push    = item_take && (grp.count != 2'd0);
  end

  // Hold the bit accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      held  <= '0;
      total <= '0;
    end else if (item_take) begin
      acc   <= acc_next;
      held  <= held_next;
      total <= item.rec_end ? '0 : total_next;
    end
  end

endmodule

>>> hdl/srqp_queue.sv
module srqp_queue import srqp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  byte_group_t push_grp,
  output logic        full,
  output logic        head_valid,
  output byte_group_t head_grp,
  input  logic        pop
);

  byte_group_t       slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full       = (fill == QCNT_W'(QDEPTH));
  assign head_valid = (fill != '0);
  assign head_grp   = slots[rd_ptr];

  // Store a group
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_grp;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/srqp_emit.sv
module srqp_emit import srqp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  byte_group_t       head_grp,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        packed_byte,
  output logic              run_last,
  output logic              record_end,
  output logic [BITS_W-1:0] record_bits
);

  logic [1:0] idx;
  logic       load, last;

  assign load = head_valid && (!out_valid || out_ready);
  assign last = (idx == head_grp.count - 2'd1);
  assign pop  = load && last;

  // Step through the bytes of the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= last ? '0 : idx + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      packed_byte <= head_grp.data[idx];
      run_last    <= last;
      record_end  <= last && head_grp.rec_end;
      record_bits <= (last && head_grp.rec_end) ? head_grp.total : '0;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import srqp_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RAND_ITEMS  = 250;
  localparam int LONG_CELLS  = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int LINGER      = 16;
  localparam int MAX_PRINTS  = 40;

  // One packed output byte as the block should present it
  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic              rec_end;
    logic [BITS_W-1:0] bits;
  } rec_byte_t;

  // Directed stimulus row: sample and, where obvious, its quantized code
  typedef struct packed {
    logic [15:0]       value;
    logic              chk;
    logic [CODE_W-1:0] code;
  } field_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] sample_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [7:0] packed_byte, [20:8] record_bits, [23:21] zero
  logic        m_tlast;        // run_last
  logic        m_tuser;        // record_end

  // Packer model state
  step_t             rec_step;
  logic [7:0]        cells_left;
  logic              dir_next;
  logic [23:0]       bit_acc;
  logic [4:0]        held_bits;
  logic [BITS_W-1:0] rec_total;

  rec_byte_t  expected_bytes[$];
  field_row_t field_rows[0:21];

  int  fail_count   = 0;
  int  fields_sent  = 0;
  int  bytes_seen   = 0;
  int  records_done = 0;
  int  quiet_cycles = 0;
  bit  src_burst    = 1'b0;
  bit  sink_burst   = 1'b0;

  sensor_record_quantize_pack u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Code of a value in tenths against its range and step, round half up
  function automatic logic [CODE_W-1:0] quantize(int t, int lo, int hi, int step, int w);
    if (t < lo) return CODE_W'((1 << w) - 2);
    if (t > hi) return CODE_W'((1 << w) - 1);
    return CODE_W'(((t - lo) + step / 2) / step);
  endfunction

  function automatic void clear_packer();
    rec_step   = STEP_PRESSURE;
    cells_left = '0;
    dir_next   = 1'b0;
    bit_acc    = '0;
    held_bits  = '0;
    rec_total  = '0;
  endfunction

  // Quantize one record field, append it to the bit stream, queue completed bytes
  task automatic pack_field(input logic [15:0] v, output logic [CODE_W-1:0] code);
    int                t;
    int                w;
    int                n;
    logic [7:0]        done[4];
    logic              closing;
    logic [7:0]        cnt;
    logic [BITS_W-1:0] bits_now;
    rec_byte_t         e;
    t = int'($signed(v));
    n = 0;
    closing = 1'b0;
    case (rec_step)
      STEP_TEMP: begin
        code = quantize(t, 0, 250, 1, W_TEMP);
        w = W_TEMP;
        rec_step = STEP_PITCH;
      end
      STEP_PITCH, STEP_ROLL: begin
        code = quantize(t, -1800, 1800, 10, W_ANGLE);
        w = W_ANGLE;
        rec_step = step_t'(rec_step + 4'd1);
      end
      STEP_HEADING: begin
        code = quantize(t, 0, 3600, 10, W_HEADING);
        w = W_HEADING;
        rec_step = STEP_BATTERY;
      end
      STEP_BATTERY: begin
        code = quantize(t, 0, 250, 1, W_BATTERY);
        w = W_BATTERY;
        rec_step = STEP_BLANKING;
      end
      STEP_BLANKING: begin
        code = CODE_W'(v[7:0]);
        w = W_BYTE;
        rec_step = STEP_CELLS;
      end
      STEP_CELLS: begin
        cnt = v[7:0];
        if (cnt > MAX_PAIRS) cnt = MAX_PAIRS;
        code = CODE_W'(cnt);
        w = W_BYTE;
        if (cnt == 8'd0) begin
          closing = 1'b1;
        end else begin
          cells_left = cnt;
          dir_next = 1'b0;
          rec_step = STEP_PAIRS;
        end
      end
      STEP_PAIRS: begin
        if (!dir_next) begin
          code = quantize(t, 0, 5000, 5, W_SPEED);
          w = W_SPEED;
          dir_next = 1'b1;
        end else begin
          code = quantize(t, 0, 3600, 50, W_DIR);
          w = W_DIR;
          dir_next = 1'b0;
          cells_left = cells_left - 8'd1;
          if (cells_left == 8'd0) closing = 1'b1;
        end
      end
      default: begin
        code = quantize(t, 0, 2500, 1, W_PRESSURE);
        w = W_PRESSURE;
        rec_step = STEP_TEMP;
      end
    endcase

    // Shift the code in and drain whole bytes, MSB first
    bit_acc = (bit_acc << w) | 24'(code);
    held_bits = held_bits + 5'(w);
    rec_total = rec_total + BITS_W'(w);
    while (held_bits >= 5'd8) begin
      done[n] = 8'(bit_acc >> (held_bits - 5'd8));
      n++;
      held_bits = held_bits - 5'd8;
      bit_acc = bit_acc & ((24'd1 << held_bits) - 24'd1);
    end

    // Flush the zero-padded tail and start over at record end
    bits_now = rec_total;
    if (closing) begin
      if (held_bits > 5'd0) begin
        done[n] = 8'(bit_acc << (5'd8 - held_bits));
        n++;
      end
      clear_packer();
      records_done++;
    end

    for (int k = 0; k < n; k++) begin
      e.data    = done[k];
      e.last    = (k == n - 1);
      e.rec_end = (k == n - 1) && closing;
      e.bits    = e.rec_end ? bits_now : '0;
      expected_bytes.push_back(e);
    end
  endtask

  // Hand one sample to the block after a random gap unless in a burst, then model it
  task automatic send_sample(input logic [15:0] v, output logic [CODE_W-1:0] code);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    fields_sent++;
    pack_field(v, code);
  endtask

  // Mostly in range, with boundary values and raw 16-bit noise mixed in
  function automatic logic [15:0] pick_value(int lo, int hi);
    case ($urandom_range(0, 9))
      0:       return 16'(lo);
      1:       return 16'(hi);
      2:       return 16'(lo - 1);
      3:       return 16'(hi + 1);
      4, 5:    return 16'($urandom);
      default: return 16'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  task automatic send_record(input logic [7:0] cells);
    logic [CODE_W-1:0] code;
    send_sample(pick_value(0, 2500), code);
    send_sample(pick_value(0, 250), code);
    send_sample(pick_value(-1800, 1800), code);
    send_sample(pick_value(-1800, 1800), code);
    send_sample(pick_value(0, 3600), code);
    send_sample(pick_value(0, 250), code);
    send_sample(16'($urandom), code);
    send_sample({8'($urandom), cells}, code);
    for (int c = 0; c < int'(cells); c++) begin
      send_sample(pick_value(0, 5000), code);
      send_sample(pick_value(0, 3600), code);
    end
  endtask

  // Receive side: random stalls, compare each transaction with the oldest expectation
  initial begin
    int        stall;
    rec_byte_t e;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      forever begin
        @(posedge clk);
        if (m_tvalid) break;
      end
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", m_tdata[7:0]));
      end else begin
        e = expected_bytes.pop_front();
        if (m_tdata[7:0] !== e.data)
          report_mismatch($sformatf("packed_byte %02h, want %02h", m_tdata[7:0], e.data));
        if (m_tlast !== e.last)
          report_mismatch($sformatf("run_last %b, want %b", m_tlast, e.last));
        if (m_tuser !== e.rec_end)
          report_mismatch($sformatf("record_end %b, want %b", m_tuser, e.rec_end));
        if (m_tdata[20:8] !== e.bits)
          report_mismatch($sformatf("record_bits %0d, want %0d", m_tdata[20:8], e.bits));
        if (m_tdata[23:21] !== 3'b000)
          report_mismatch($sformatf("pad bits %b, want 000", m_tdata[23:21]));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [CODE_W-1:0] code;
    logic [7:0]        cells;
    int                rand_start;

    // Record with three cells: range extremes, out-of-range codes, rounding
    field_rows[0]  = '{16'hFFFF,      1'b1, 12'd4094};  // pressure below range
    field_rows[1]  = '{16'd251,       1'b1, 12'd511};   // temperature above range
    field_rows[2]  = '{16'(-1800),    1'b1, 12'd0};     // pitch at minimum
    field_rows[3]  = '{16'd1800,      1'b1, 12'd360};   // roll at maximum
    field_rows[4]  = '{16'd3600,      1'b1, 12'd360};   // heading at maximum
    field_rows[5]  = '{16'd0,         1'b1, 12'd0};     // battery at minimum
    field_rows[6]  = '{16'hABCD,      1'b1, 12'd205};   // blanking keeps low byte
    field_rows[7]  = '{16'h0103,      1'b1, 12'd3};     // three cells, high byte dropped
    field_rows[8]  = '{16'd5000,      1'b1, 12'd1000};  // speed at maximum
    field_rows[9]  = '{16'd3600,      1'b1, 12'd72};    // direction at maximum
    field_rows[10] = '{16'h8000,      1'b1, 12'd1022};  // speed most negative
    field_rows[11] = '{16'h7FFF,      1'b1, 12'd127};   // direction most positive
    field_rows[12] = '{16'd3,         1'b0, 12'd0};     // speed rounds up
    field_rows[13] = '{16'd24,        1'b0, 12'd0};     // direction rounds down
    // Record with zero cells: ends right after the cell-count byte
    field_rows[14] = '{16'd2500,      1'b1, 12'd2500};
    field_rows[15] = '{16'h8000,      1'b1, 12'd510};
    field_rows[16] = '{16'(-1801),    1'b1, 12'd510};
    field_rows[17] = '{16'd1801,      1'b1, 12'd511};
    field_rows[18] = '{16'd3601,      1'b1, 12'd511};
    field_rows[19] = '{16'd250,       1'b1, 12'd250};
    field_rows[20] = '{16'hFF00,      1'b1, 12'd0};
    field_rows[21] = '{16'h0100,      1'b1, 12'd0};

    clear_packer();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    for (int i = 0; i < 22; i++) begin
      send_sample(field_rows[i].value, code);
      if (field_rows[i].chk && code !== field_rows[i].code)
        report_mismatch($sformatf("row %0d code %0d, want %0d", i, code,
                                  field_rows[i].code));
    end

    // Random records, mostly a few cells, some empty, some longer
    rand_start = fields_sent;
    while (fields_sent - rand_start < RAND_ITEMS) begin
      src_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       cells = 8'd0;
        1:       cells = 8'($urandom_range(7, 24));
        default: cells = 8'($urandom_range(1, 6));
      endcase
      send_record(cells);
    end

    // One long record to close the run
    src_burst = 1'b0;
    send_record(8'(LONG_CELLS));
    s_tvalid <= 1'b0;

    // Drain, then watch for stray bytes
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (LINGER) @(posedge clk);

    $display("Sent %0d fields in %0d records; checked %0d packed bytes.",
             fields_sent, records_done, bytes_seen);
    $display("Covered range extremes, empty and long records, random stalls.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
